### rtl/core/serial_rx_fifo_command_decode_unit_assert.svh
// Assertion macros for the receive byte FIFO with command decode
`ifndef SERIAL_RX_FIFO_COMMAND_DECODE_UNIT_ASSERT_SVH
`define SERIAL_RX_FIFO_COMMAND_DECODE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SRFCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define SRFCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/srfcd_pkg.sv
// Shared types, codes and the command decode function for the receive FIFO
package srfcd_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [3:0] cmd_t;
	typedef logic [31:0] count_t;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam cmd_t  CMD_NONE     = 4'd0;
	localparam cmd_t  CMD_DIGIT8   = 4'd12;
	localparam cmd_t  CMD_DIGIT9   = 4'd13;
	localparam byte_t BYTE_LETTER_LO = 8'h41;
	localparam byte_t BYTE_LETTER_HI = 8'h4B;
	localparam byte_t BYTE_LETTER_BASE = 8'h40;
	localparam byte_t BYTE_DIGIT8  = 8'h38;
	localparam byte_t BYTE_DIGIT9  = 8'h39;

	function automatic cmd_t decode_cmd(input byte_t b);
		byte_t diff;
		diff = b - BYTE_LETTER_BASE;
		if (b >= BYTE_LETTER_LO && b <= BYTE_LETTER_HI)
			return diff[3:0];
		else if (b == BYTE_DIGIT8)
			return CMD_DIGIT8;
		else if (b == BYTE_DIGIT9)
			return CMD_DIGIT9;
		else
			return CMD_NONE;
	endfunction

endpackage

### rtl/core/srfcd_store.sv
// Byte storage RAM: one write port, one read port with registered read data
module srfcd_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  srfcd_pkg::byte_t     wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output srfcd_pkg::byte_t     rd_data
);

	srfcd_pkg::byte_t mem_q [DEPTH];
	srfcd_pkg::byte_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	// holds its value while the consumer stalls
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/serial_rx_fifo_command_decode_unit.sv
// Receive byte FIFO (one slot kept empty) with command decode and status counters
//
// Input beats (s_*): s_tuser selects the operation (0 push, 1 pop), s_tdata
// carries the received byte, used only on a push. Each accepted beat yields
// exactly one output beat (m_*): m_tuser is the pop valid flag, m_tdata the
// popped byte and its command code plus the status as it stands after the
// operation (accepted and overflow counters, last accepted byte and command).
// Holds at most DEPTH-1 bytes; a push into a full buffer only bumps the
// overflow counter. Commands: 0x41..0x4B give 1..11, 0x38 gives 12, 0x39 13.
// Throughput is one beat per cycle unless m_tready stalls the output. From
// input accept to output valid, the storage RAM registers its read data with
// the middle stage, then the result lands in the output register. Pointers
// and counters update at the accept edge; a following beat sees them at once.
// A stalled m_tready holds the output register; the middle stage and then
// s_tready back up behind it, so no beat is lost.
// Reset clears pointers, counters and last byte/command; the buffer is empty
// and ready to accept as soon as reset is released.
module serial_rx_fifo_command_decode_unit #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [7:0] popped_byte, [11:8] popped_command,
	                               // [43:12] accepted_total, [75:44] overflow_total,
	                               // [83:76] last_byte, [87:84] last_command
	output logic        m_tuser    // [0] pop_valid
);

	localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	// state
	logic [AW-1:0]       wr_ptr_q, rd_ptr_q;
	srfcd_pkg::count_t   acc_cnt_q, ovf_cnt_q;
	srfcd_pkg::byte_t    last_byte_q;
	srfcd_pkg::cmd_t     last_cmd_q;

	// middle stage
	logic                valid_s1;
	logic                pop_ok_s1;
	srfcd_pkg::count_t   acc_s1, ovf_s1;
	srfcd_pkg::byte_t    last_byte_s1;
	srfcd_pkg::cmd_t     last_cmd_s1;

	// output register
	logic                m_tvalid_q;
	logic                m_tuser_q;
	logic [87:0]         m_tdata_q;

	logic                in_beat, is_push, is_pop, full, empty;
	logic                do_write, do_read, advance_s1;
	logic [AW-1:0]       wr_next, rd_next;
	srfcd_pkg::count_t   acc_next, ovf_next;
	srfcd_pkg::byte_t    last_byte_next, rd_byte, pop_byte;
	srfcd_pkg::cmd_t     last_cmd_next, pop_cmd;

	assign advance_s1 = !m_tvalid_q || m_tready;
	assign s_tready   = !valid_s1 || advance_s1;
	assign in_beat    = s_tvalid && s_tready;
	assign is_push    = (s_tuser == srfcd_pkg::OP_PUSH);
	assign is_pop     = (s_tuser == srfcd_pkg::OP_POP);

	assign wr_next = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
	assign rd_next = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
	assign full    = (wr_next == rd_ptr_q);
	assign empty   = (wr_ptr_q == rd_ptr_q);

	assign do_write = in_beat && is_push && !full;
	assign do_read  = in_beat && is_pop && !empty;

	always_comb begin
		acc_next       = acc_cnt_q;
		ovf_next       = ovf_cnt_q;
		last_byte_next = last_byte_q;
		last_cmd_next  = last_cmd_q;
		if (do_write) begin
			acc_next       = acc_cnt_q + 32'd1;
			last_byte_next = s_tdata;
			last_cmd_next  = srfcd_pkg::decode_cmd(s_tdata);
		end else if (in_beat && is_push) begin
			ovf_next = ovf_cnt_q + 32'd1;
		end
	end

	srfcd_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_addr (wr_ptr_q),
		.wr_data (s_tdata),
		.rd_en   (do_read),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			acc_cnt_q   <= '0;
			ovf_cnt_q   <= '0;
			last_byte_q <= '0;
			last_cmd_q  <= srfcd_pkg::CMD_NONE;
		end else begin
			if (do_write)
				wr_ptr_q <= wr_next;
			if (do_read)
				rd_ptr_q <= rd_next;
			acc_cnt_q   <= acc_next;
			ovf_cnt_q   <= ovf_next;
			last_byte_q <= last_byte_next;
			last_cmd_q  <= last_cmd_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= in_beat;
			if (advance_s1)
				m_tvalid_q <= valid_s1;
		end
	end

	// status snapshot taken with the beat; popped byte comes from the RAM read register loaded at the same edge
	always_ff @(posedge clk) begin
		if (in_beat) begin
			pop_ok_s1    <= do_read;
			acc_s1       <= acc_next;
			ovf_s1       <= ovf_next;
			last_byte_s1 <= last_byte_next;
			last_cmd_s1  <= last_cmd_next;
		end
	end

	assign pop_byte = pop_ok_s1 ? rd_byte : '0;
	assign pop_cmd  = srfcd_pkg::decode_cmd(pop_byte);

	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1) begin
			m_tuser_q <= pop_ok_s1;
			m_tdata_q <= {last_cmd_s1, last_byte_s1, ovf_s1, acc_s1, pop_cmd, pop_byte};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

`include "serial_rx_fifo_command_decode_unit_assert.svh"

	`SRFCD_ASSERT_NOW(a_ptr_range, 1'b1, (wr_ptr_q <= LAST_SLOT) && (rd_ptr_q <= LAST_SLOT), "pointer out of range")
	`SRFCD_ASSERT_NEXT(a_ovf_on_full, in_beat && is_push && full, (ovf_cnt_q == $past(ovf_cnt_q) + 32'd1) && $stable(wr_ptr_q), "push on full mishandled")
	`SRFCD_ASSERT_NEXT(a_acc_only_push, !do_write, $stable(acc_cnt_q) && $stable(last_byte_q), "accepted state moved without a push")
	`SRFCD_ASSERT_NEXT(a_empty_pop_hold, in_beat && is_pop && empty, $stable(rd_ptr_q), "pop on empty moved read pointer")

endmodule
